[src/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rau_pkg.sv]
// Package for the rational arithmetic unit: constants, opcodes, states and the divider control struct.
package rau_pkg;

    localparam int OPERAND_BITS = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_RED_N_START,
        ST_RED_N_WAIT,
        ST_RED_D_START,
        ST_RED_D_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

[src/rational_arith_unit_top.sv]
// Top level of the rational arithmetic unit.
//
// Usage: one transaction on the s_ channel carries an opcode and two unsigned
// fractions; one transaction on the m_ channel returns the unreduced result.
// Each operand whose numerator and denominator are both nonzero is reduced
// by its GCD, found with Euclid's algorithm on a shared radix-2 divider,
// which also performs the two reduction divisions; such an operand takes
// (k+2) divisions, k being its Euclid step count. The products are formed
// in turn on one shared multiplier. One item is processed at a time:
// s_axis_tready is high only while the unit is idle and no result is
// pending. The result stays in the output register while m_axis_tready is
// low and the next item is taken after it is read. Reset (aresetn low,
// synchronous) returns the sequencer to idle and drops m_axis_tvalid.
`include "assert_macros.svh"

module rational_arith_unit_top #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // op, left_num, left_den, right_num, right_den; zero pad to bytes
    input  logic [((4*OPERAND_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result_num, result_den; zero pad to bytes
    output logic [((4*OPERAND_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W     = OPERAND_BITS;
    localparam int PW    = 2 * W;
    localparam int NW    = 2 * W + 2;
    localparam int TW    = ((4 * W + 2 + 7) / 8) * 8;

    rau_pkg::state_t state_reg, state_next;

    logic [1:0]   op_reg, op_next;
    logic [W-1:0] n_reg [2];
    logic [W-1:0] d_reg [2];
    logic [W-1:0] n_next [2];
    logic [W-1:0] d_next [2];
    logic         sel_reg, sel_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [PW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [NW-1:0] rn_reg, rn_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic          mv_reg, mv_next;

    logic          dv_start;
    logic [W-1:0]  dv_a, dv_b, dv_q, dv_r;
    rau_pkg::div_ctl_t dv_ctl;

    logic [W-1:0]  ma, mb;
    logic [PW-1:0] mp;

    rau_divider #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dv_start),
        .dividend  (dv_a),
        .divisor   (dv_b),
        .ctl       (dv_ctl),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    assign mp = PW'(ma) * PW'(mb);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        op_reg  <= op_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        sel_reg <= sel_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        g_reg   <= g_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sel_next   = sel_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        mv_next    = mv_reg;
        dv_start   = 1'b0;
        dv_a       = x_reg;
        dv_b       = y_reg;
        ma         = n_reg[0];
        mb         = d_reg[1];
        if (mv_reg && m_axis_tready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_axis_tvalid && !mv_reg) begin
                    op_next    = s_axis_tdata[1:0];
                    n_next[0]  = s_axis_tdata[2 +: W];
                    d_next[0]  = s_axis_tdata[2+W +: W];
                    n_next[1]  = s_axis_tdata[2+2*W +: W];
                    d_next[1]  = s_axis_tdata[2+3*W +: W];
                    sel_next   = 1'b0;
                    state_next = rau_pkg::ST_GCD_START;
                end
            end
            rau_pkg::ST_GCD_START: begin
                if (n_reg[sel_reg] == '0 || d_reg[sel_reg] == '0) begin
                    state_next = sel_reg ? rau_pkg::ST_MUL1 : rau_pkg::ST_GCD_START;
                    sel_next   = 1'b1;
                end else begin
                    x_next     = n_reg[sel_reg];
                    y_next     = d_reg[sel_reg];
                    state_next = rau_pkg::ST_GCD_WAIT;
                end
            end
            rau_pkg::ST_GCD_WAIT: begin
                if (y_reg == '0) begin
                    g_next     = x_reg;
                    state_next = rau_pkg::ST_RED_N_START;
                end else if (!dv_ctl.busy && !dv_ctl.done) begin
                    dv_start = 1'b1;
                end else if (dv_ctl.done) begin
                    x_next = y_reg;
                    y_next = dv_r;
                end
            end
            rau_pkg::ST_RED_N_START: begin
                dv_a       = n_reg[sel_reg];
                dv_b       = g_reg;
                dv_start   = 1'b1;
                state_next = rau_pkg::ST_RED_N_WAIT;
            end
            rau_pkg::ST_RED_N_WAIT: begin
                if (dv_ctl.done) begin
                    n_next[sel_reg] = dv_q;
                    state_next      = rau_pkg::ST_RED_D_START;
                end
            end
            rau_pkg::ST_RED_D_START: begin
                dv_a       = d_reg[sel_reg];
                dv_b       = g_reg;
                dv_start   = 1'b1;
                state_next = rau_pkg::ST_RED_D_WAIT;
            end
            rau_pkg::ST_RED_D_WAIT: begin
                if (dv_ctl.done) begin
                    d_next[sel_reg] = dv_q;
                    sel_next        = 1'b1;
                    state_next      = sel_reg ? rau_pkg::ST_MUL1 : rau_pkg::ST_GCD_START;
                end
            end
            rau_pkg::ST_MUL1: begin
                ma = n_reg[0];
                case (op_reg)
                    rau_pkg::OP_MUL: mb = n_reg[1];
                    default:         mb = d_reg[1];
                endcase
                p1_next    = mp;
                state_next = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                case (op_reg)
                    rau_pkg::OP_DIV: begin
                        ma = d_reg[0];
                        mb = n_reg[1];
                    end
                    default: begin
                        ma = d_reg[0];
                        mb = d_reg[1];
                    end
                endcase
                p2_next    = mp;
                state_next = rau_pkg::ST_COMBINE;
            end
            rau_pkg::ST_COMBINE: begin
                ma = d_reg[0];
                mb = n_reg[1];
                unique case (op_reg)
                    rau_pkg::OP_ADD: rn_next = NW'(p1_reg) + NW'(mp);
                    rau_pkg::OP_SUB: rn_next = NW'(p1_reg) - NW'(mp);
                    rau_pkg::OP_MUL: rn_next = NW'(p1_reg);
                    default:         rn_next = (p2_reg == '0) ? '0 : NW'(p1_reg);
                endcase
                if (op_reg == rau_pkg::OP_DIV && p2_reg == '0) begin
                    rd_next = PW'(1);
                end else begin
                    rd_next = p2_reg;
                end
                state_next = rau_pkg::ST_OUT;
            end
            rau_pkg::ST_OUT: begin
                mv_next    = 1'b1;
                state_next = rau_pkg::ST_IDLE;
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == rau_pkg::ST_IDLE) && !mv_reg;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = TW'({rd_reg, rn_reg});

    `ASSERT_IMPL(a_out_idle, aclk, aresetn, mv_reg, state_reg == rau_pkg::ST_IDLE, "result pending while busy")
    `ASSERT_NEXT(a_out_set, aclk, aresetn, state_reg == rau_pkg::ST_OUT, mv_reg, "result not presented")
    `ASSERT_IMPL(a_div_rden, aclk, aresetn, mv_reg && (op_reg == rau_pkg::OP_DIV), rd_reg != '0, "zero denominator after divide")

endmodule

[src/rau_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`include "assert_macros.svh"

module rau_divider #(
    parameter int W = rau_pkg::OPERAND_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W-1:0]     dividend,
    input  logic [W-1:0]     divisor,
    output rau_pkg::div_ctl_t ctl,
    output logic [W-1:0]     quotient,
    output logic [W-1:0]     remainder
);

    localparam int CW = $clog2(W + 1);

    rau_pkg::div_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        trial      = {r_reg, q_reg[W-1]};
        diff       = trial - {1'b0, d_reg};
        unique case (state_reg)
            rau_pkg::DIV_IDLE: begin
                if (start) begin
                    q_next     = dividend;
                    r_next     = '0;
                    d_next     = divisor;
                    cnt_next   = CW'(W);
                    state_next = rau_pkg::DIV_RUN;
                end
            end
            rau_pkg::DIV_RUN: begin
                if (!diff[W]) begin
                    r_next = diff[W-1:0];
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    r_next = trial[W-1:0];
                    q_next = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = rau_pkg::DIV_DONE;
                end
            end
            rau_pkg::DIV_DONE: begin
                state_next = rau_pkg::DIV_IDLE;
            end
            default: state_next = rau_pkg::DIV_IDLE;
        endcase
    end

    assign ctl.start  = start;
    assign ctl.busy   = (state_reg == rau_pkg::DIV_RUN);
    assign ctl.done   = (state_reg == rau_pkg::DIV_DONE);
    assign quotient   = q_reg;
    assign remainder  = r_reg;

    `ASSERT_NEXT(a_div_last, aclk, aresetn, (state_reg == rau_pkg::DIV_RUN) && (cnt_reg == CW'(1)), state_reg == rau_pkg::DIV_DONE, "divider did not finish")
    `ASSERT_IMPL(a_div_cnt, aclk, aresetn, state_reg == rau_pkg::DIV_RUN, cnt_reg != '0, "divider count zero while running")

endmodule
